[hdl/mbss_pkg.sv]
// ----------------------------------------------------------------------------
// mbss_pkg - shared types and constants
// Item and command layouts, function and exception codes, CRC16 byte step.
// ----------------------------------------------------------------------------
`default_nettype none

package mbss_pkg;

    localparam int NUM_STG     = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FUNC_RD_HOLD   = 8'h03;
    localparam logic [7:0] FUNC_RD_INPUT  = 8'h04;
    localparam logic [7:0] FUNC_WR_SINGLE = 8'h06;
    localparam logic [7:0] EXC_FLAG       = 8'h80;
    localparam logic [7:0] EXC_ILL_FUNC   = 8'h01;
    localparam logic [7:0] EXC_ILL_ADDR   = 8'h02;
    localparam logic [7:0] REG_TEMP       = 8'h01;
    localparam logic [7:0] REG_HUM        = 8'h02;
    localparam logic [7:0] BYTES_ONE_REG  = 8'h02;
    localparam logic [7:0] BYTES_TWO_REG  = 8'h04;

    localparam logic [7:0] STATION_RST  = 8'd5;
    localparam logic [7:0] TEMP_LO_RST  = 8'd10;
    localparam logic [7:0] TEMP_HI_RST  = 8'd35;
    localparam logic [7:0] HUM_LO_RST   = 8'd0;
    localparam logic [7:0] HUM_HI_RST   = 8'd100;

    typedef enum logic [3:0] {
        KIND_MEAS     = 4'd0,
        KIND_EXC_FUNC = 4'd1,
        KIND_EXC_ADDR = 4'd2,
        KIND_WRITE    = 4'd3,
        KIND_RD_LIM   = 4'd4,
        KIND_RD_HUM   = 4'd5,
        KIND_RD_T1    = 4'd6,
        KIND_RD_T2    = 4'd7
    } cmd_kind_t;

    typedef struct packed {
        logic              opcode;
        logic [7:0][7:0]   frame;
        logic signed [7:0] temp;
        logic [6:0]        hum;
    } item_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [5:0][7:0]   frame;
        logic signed [7:0] temp;
        logic [6:0]        hum;
    } cmd_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/mbss_front.sv]
// ----------------------------------------------------------------------------
// mbss_front - request check and classification
// Pipelined CRC16 over the first six frame bytes, one byte per stage, then
// address check and decode into a command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mbss_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic [7:0]     station_address,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [79:0]    s_tdata,
    input  wire logic           s_tuser,
    output logic                push_valid,
    input  wire logic           push_ready,
    output mbss_pkg::cmd_t      push_data
);
    import mbss_pkg::*;

    item_t                in_item;
    item_t                stg_item_reg [NUM_STG];
    logic [15:0]          stg_crc_reg  [NUM_STG];
    logic [NUM_STG-1:0]   stg_valid_reg;
    logic                 adv;
    item_t                f;
    logic [15:0]          c;
    logic                 crc_ok;
    logic                 addr_ok;
    logic                 drop;
    cmd_kind_t            kind;

    always_comb begin
        in_item.opcode = s_tuser;
        in_item.frame  = s_tdata[63:0];
        in_item.temp   = s_tdata[71:64];
        in_item.hum    = s_tdata[78:72];
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= '0;
        end else if (adv) begin
            stg_valid_reg <= {stg_valid_reg[NUM_STG-2:0], s_tvalid};
        end
    end

    // crc stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            stg_item_reg[0] <= in_item;
            stg_crc_reg[0]  <= crc_byte(CRC_INIT, in_item.frame[0]);
            for (int k = 1; k < NUM_STG; k++) begin
                stg_item_reg[k] <= stg_item_reg[k-1];
                stg_crc_reg[k]  <= crc_byte(stg_crc_reg[k-1], stg_item_reg[k-1].frame[k]);
            end
        end
    end

    always_comb begin
        f       = stg_item_reg[NUM_STG-1];
        c       = stg_crc_reg[NUM_STG-1];
        crc_ok  = (c == {f.frame[7], f.frame[6]});
        addr_ok = (f.frame[0] == station_address);
        drop    = !f.opcode && (!crc_ok || !addr_ok);

        if (f.opcode) begin
            kind = KIND_MEAS;
        end else if (!(f.frame[1] inside {FUNC_RD_HOLD, FUNC_RD_INPUT, FUNC_WR_SINGLE})) begin
            kind = KIND_EXC_FUNC;
        end else if (f.frame[2] != 8'h00 || !(f.frame[3] inside {REG_TEMP, REG_HUM})) begin
            kind = KIND_EXC_ADDR;
        end else if (f.frame[1] == FUNC_WR_SINGLE) begin
            kind = KIND_WRITE;
        end else if (f.frame[1] == FUNC_RD_HOLD) begin
            kind = KIND_RD_LIM;
        end else if (f.frame[3] == REG_HUM) begin
            kind = (f.frame[4] == 8'h00 && f.frame[5] == 8'h01) ? KIND_RD_HUM : KIND_EXC_ADDR;
        end else if (f.frame[4] != 8'h00 || !(f.frame[5] inside {8'h01, 8'h02})) begin
            kind = KIND_EXC_ADDR;
        end else begin
            kind = (f.frame[5] == 8'h01) ? KIND_RD_T1 : KIND_RD_T2;
        end

        push_data.kind  = kind;
        push_data.frame = f.frame[5:0];
        push_data.temp  = f.temp;
        push_data.hum   = f.hum;
        push_valid      = stg_valid_reg[NUM_STG-1] && !drop;
        adv             = !stg_valid_reg[NUM_STG-1] || drop || push_ready;
        s_tready        = adv;
    end

endmodule

`default_nettype wire

[hdl/mbss_queue.sv]
// ----------------------------------------------------------------------------
// mbss_queue - command queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mbss_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire mbss_pkg::cmd_t push_data,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output mbss_pkg::cmd_t      pop_data
);
    import mbss_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    always_comb begin
        push_ready  = (count_reg != QUEUE_DEPTH[QPTR_W:0]);
        pop_valid   = (count_reg != '0);
        pop_data    = mem_reg[rd_ptr_reg];
        do_push     = push_valid && push_ready;
        do_pop      = pop_valid && pop_ready;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[hdl/mbss_back.sv]
// ----------------------------------------------------------------------------
// mbss_back - command execution and reply output
// Holds limits and latest measurement, builds replies and sends them one
// word per cycle while m_tready allows, with the CRC16 worked out on the way.
// ----------------------------------------------------------------------------
`default_nettype none

module mbss_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wire mbss_pkg::cmd_t pop_data,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [15:0]         m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);
    import mbss_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    logic [6:0][7:0] buf_reg, buf_next;
    logic [2:0]      len_reg, len_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic [15:0]     crc_reg, crc_next;
    logic [7:0]      t_lo_reg, t_lo_next, t_hi_reg, t_hi_next;
    logic [7:0]      h_lo_reg, h_lo_next, h_hi_reg, h_hi_next;
    logic [7:0]      temp_reg, temp_next;
    logic [6:0]      hum_reg, hum_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [7:0]      m_byte_reg, m_byte_next;
    logic            m_alarm_reg, m_alarm_next;
    logic            m_tlast_reg, m_tlast_next;
    logic            m_tuser_reg, m_tuser_next;
    logic            out_free;
    logic            pop;
    cmd_t            cmd;
    logic [7:0]      sx;
    logic [8:0]      t9;

    always_comb begin
        state_next    = state_reg;
        buf_next      = buf_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        crc_next      = crc_reg;
        t_lo_next     = t_lo_reg;
        t_hi_next     = t_hi_reg;
        h_lo_next     = h_lo_reg;
        h_hi_next     = h_hi_reg;
        temp_next     = temp_reg;
        hum_next      = hum_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_byte_next   = m_byte_reg;
        m_alarm_next  = m_alarm_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;

        out_free  = !m_tvalid_reg || m_tready;
        pop_ready = (state_reg == ST_IDLE) && out_free;
        pop       = pop_valid && pop_ready;
        cmd       = pop_data;
        sx        = {8{temp_reg[7]}};
        t9        = {cmd.temp[7], cmd.temp};

        if (pop) begin
            crc_next   = CRC_INIT;
            cnt_next   = '0;
            buf_next   = '0;
            state_next = ST_SEND;
            buf_next[0] = cmd.frame[0];
            buf_next[1] = cmd.frame[1];
            case (cmd.kind)
                KIND_MEAS: begin
                    state_next    = ST_IDLE;
                    temp_next     = cmd.temp;
                    hum_next      = cmd.hum;
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = 1'b0;
                    m_byte_next   = 8'h00;
                    m_alarm_next  = ($signed(t9) < $signed({1'b0, t_lo_reg}))
                                 || ($signed(t9) > $signed({1'b0, t_hi_reg}))
                                 || ({1'b0, cmd.hum} < h_lo_reg)
                                 || ({1'b0, cmd.hum} > h_hi_reg);
                end
                KIND_EXC_FUNC, KIND_EXC_ADDR: begin
                    buf_next[1] = cmd.frame[1] | EXC_FLAG;
                    buf_next[2] = (cmd.kind == KIND_EXC_FUNC) ? EXC_ILL_FUNC : EXC_ILL_ADDR;
                    len_next    = 3'd3;
                end
                KIND_WRITE: begin
                    if (cmd.frame[3] == REG_HUM) begin
                        h_lo_next = cmd.frame[4];
                        h_hi_next = cmd.frame[5];
                    end else begin
                        t_lo_next = cmd.frame[4];
                        t_hi_next = cmd.frame[5];
                    end
                    buf_next[5:0] = cmd.frame;
                    len_next      = 3'd6;
                end
                KIND_RD_LIM: begin
                    buf_next[2] = BYTES_ONE_REG;
                    buf_next[3] = (cmd.frame[3] == REG_HUM) ? h_lo_reg : t_lo_reg;
                    buf_next[4] = (cmd.frame[3] == REG_HUM) ? h_hi_reg : t_hi_reg;
                    len_next    = 3'd5;
                end
                KIND_RD_HUM: begin
                    buf_next[2] = BYTES_ONE_REG;
                    buf_next[3] = 8'h00;
                    buf_next[4] = {1'b0, hum_reg};
                    len_next    = 3'd5;
                end
                KIND_RD_T1: begin
                    buf_next[2] = BYTES_ONE_REG;
                    buf_next[3] = sx;
                    buf_next[4] = temp_reg;
                    len_next    = 3'd5;
                end
                KIND_RD_T2: begin
                    buf_next[2] = BYTES_TWO_REG;
                    buf_next[3] = sx;
                    buf_next[4] = temp_reg;
                    buf_next[5] = 8'h00;
                    buf_next[6] = {1'b0, hum_reg};
                    len_next    = 3'd7;
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end else if (state_reg == ST_SEND && out_free) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = 1'b0;
            m_alarm_next  = 1'b0;
            m_tlast_next  = 1'b0;
            cnt_next      = cnt_reg + 1'b1;
            if (cnt_reg < {1'b0, len_reg}) begin
                m_byte_next = buf_reg[0];
                crc_next    = crc_byte(crc_reg, buf_reg[0]);
                buf_next    = {8'h00, buf_reg[6:1]};
            end else if (cnt_reg == {1'b0, len_reg}) begin
                m_byte_next = crc_reg[7:0];
            end else begin
                m_byte_next  = crc_reg[15:8];
                m_tlast_next = 1'b1;
                state_next   = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            t_lo_reg     <= TEMP_LO_RST;
            t_hi_reg     <= TEMP_HI_RST;
            h_lo_reg     <= HUM_LO_RST;
            h_hi_reg     <= HUM_HI_RST;
            temp_reg     <= '0;
            hum_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            t_lo_reg     <= t_lo_next;
            t_hi_reg     <= t_hi_next;
            h_lo_reg     <= h_lo_next;
            h_hi_reg     <= h_hi_next;
            temp_reg     <= temp_next;
            hum_reg      <= hum_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg     <= buf_next;
        len_reg     <= len_next;
        cnt_reg     <= cnt_next;
        crc_reg     <= crc_next;
        m_byte_reg  <= m_byte_next;
        m_alarm_reg <= m_alarm_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_alarm_reg, m_byte_reg};
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEND |-> cnt_reg <= ({1'b0, len_reg} + 4'd1))
        else $error("reply word counter past end of reply");

    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg |-> !m_tlast_reg && m_byte_reg == 8'h00)
        else $error("alarm status word carries reply fields");

    a_last_word: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEND && out_free && cnt_reg == ({1'b0, len_reg} + 4'd1)
        |=> m_tvalid_reg && m_tlast_reg && state_reg == ST_IDLE)
        else $error("crc high word not sent as last word");

endmodule

`default_nettype wire

[hdl/modbus_sensor_slave_responder.sv]
// ----------------------------------------------------------------------------
// modbus_sensor_slave_responder - sensor node slave responder
// s_ channel: one word per request frame (tuser 0) or measurement (tuser 1).
// tdata from bit 0: frame bytes 0..7, temperature (8, signed), humidity (7).
// m_ channel: tuser 0 words are reply bytes, tlast on the CRC high byte;
// a tuser 1 word carries the alarm status of a measurement.
// tdata from bit 0: tx byte (8), alarm (1).
// cfg_ channel writes the station address; write it only while idle.
// Frames pass a six-stage CRC pipeline and a four-entry command queue to
// the back end, which loads each command and then sends its reply one word
// per cycle while m_tready is high; a measurement gives one status word.
// The four-entry command queue lets new words be taken while a reply goes out.
// Frames with a bad CRC or a foreign address are dropped silently.
// Reset restores station address 5, default limits and zeroed readings.
// A stalled m_ side fills the queue and then holds s_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_sensor_slave_responder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // frame_byte_0..7, temperature, humidity
    input  wire logic        s_tuser,   // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // tx_byte, alarm
    output logic             m_tlast,
    output logic             m_tuser,   // result_kind
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);
    import mbss_pkg::*;

    logic [7:0] station_reg;
    logic       push_valid;
    logic       push_ready;
    cmd_t       push_data;
    logic       pop_valid;
    logic       pop_ready;
    cmd_t       pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            station_reg <= STATION_RST;
        end else if (cfg_valid && cfg_ready) begin
            station_reg <= cfg_data;
        end
    end

    mbss_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .station_address (station_reg),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_data       (push_data)
    );

    mbss_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mbss_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

[tb/sv/mbss_reply_checker.sv]
// ----------------------------------------------------------------------------
// mbss_reply_checker - scoreboard for the sensor node slave responder
// Snoops the s_, m_ and cfg_ channels and keeps its own copy of the station
// address, limits and latest readings. Every word taken on s_ is turned into
// the reply bytes or alarm status it must cause, if any, and each word leaving on m_
// is compared field by field with the oldest of them.
// ----------------------------------------------------------------------------
package mbss_tb_pkg;

    import mbss_pkg::*;

    localparam logic OP_FRAME      = 1'b0;
    localparam logic OP_MEAS       = 1'b1;
    localparam logic RESULT_REPLY  = 1'b0;
    localparam logic RESULT_STATUS = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
        logic       alarm;
    } reply_word_t;

    // crc16 over the first n bytes, byte 0 first
    function automatic logic [15:0] modbus_crc(input logic [8:0][7:0] b, input int n);
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = 0; i < n; i++) begin
            c = c ^ {8'h00, b[i]};
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
        end
        return c;
    endfunction

endpackage

module mbss_reply_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [79:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic        m_tlast,
    input  wire logic        m_tuser,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [7:0]  cfg_data,
    output int               fail_count,
    output int               pending_count,
    output int               reply_count,
    output int               status_count
);

    import mbss_pkg::*;
    import mbss_tb_pkg::*;

    logic [7:0]  station;
    logic [7:0]  temp_lo;
    logic [7:0]  temp_hi;
    logic [7:0]  hum_lo;
    logic [7:0]  hum_hi;
    logic [7:0]  last_temp;
    logic [6:0]  last_hum;
    reply_word_t expected_words[$];
    reply_word_t w;
    int          errors = 0;
    int          replies = 0;
    int          statuses = 0;
    int          t_val;
    logic        alarm;

    initial begin
        fail_count    = 0;
        pending_count = 0;
        reply_count   = 0;
        status_count  = 0;
    end

    task automatic report(input string what, input int got, input int want);
        if (errors < 50) begin
            $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        end
        errors++;
    endtask

    task automatic queue_reply(input logic [8:0][7:0] msg, input int n);
        logic [15:0] crc;
        crc = modbus_crc(msg, n);
        msg[n]     = crc[7:0];
        msg[n + 1] = crc[15:8];
        for (int k = 0; k < n + 2; k++) begin
            expected_words.push_back('{RESULT_REPLY, msg[k], k == n + 1, 1'b0});
        end
    endtask

    task automatic queue_exception(input logic [7:0] func, input logic [7:0] code);
        logic [8:0][7:0] msg;
        msg    = '0;
        msg[0] = station;
        msg[1] = func | EXC_FLAG;
        msg[2] = code;
        queue_reply(msg, 3);
    endtask

    task automatic predict_frame(input logic [7:0][7:0] f);
        logic [8:0][7:0] msg;
        logic [15:0]     crc;
        logic [7:0]      reg_sel;
        msg     = '0;
        crc     = modbus_crc({8'h00, f}, 6);
        reg_sel = (f[2] == 8'h00 && (f[3] == REG_TEMP || f[3] == REG_HUM)) ? f[3] : 8'h00;
        msg[0]  = station;
        msg[1]  = f[1];
        if (crc != {f[7], f[6]} || f[0] != station) begin
            // dropped without a reply
        end else if (f[1] != FUNC_RD_HOLD && f[1] != FUNC_RD_INPUT
                     && f[1] != FUNC_WR_SINGLE) begin
            queue_exception(f[1], EXC_ILL_FUNC);
        end else if (reg_sel == 8'h00) begin
            queue_exception(f[1], EXC_ILL_ADDR);
        end else if (f[1] == FUNC_WR_SINGLE) begin
            if (reg_sel == REG_TEMP) begin
                temp_lo = f[4];
                temp_hi = f[5];
            end else begin
                hum_lo = f[4];
                hum_hi = f[5];
            end
            for (int k = 0; k < 8; k++) begin
                expected_words.push_back('{RESULT_REPLY, f[k], k == 7, 1'b0});
            end
        end else if (f[1] == FUNC_RD_HOLD) begin
            msg[2] = BYTES_ONE_REG;
            msg[3] = (reg_sel == REG_TEMP) ? temp_lo : hum_lo;
            msg[4] = (reg_sel == REG_TEMP) ? temp_hi : hum_hi;
            queue_reply(msg, 5);
        end else if (reg_sel == REG_HUM) begin
            if (f[4] != 8'h00 || f[5] != 8'h01) begin
                queue_exception(f[1], EXC_ILL_ADDR);
            end else begin
                msg[2] = BYTES_ONE_REG;
                msg[3] = 8'h00;
                msg[4] = {1'b0, last_hum};
                queue_reply(msg, 5);
            end
        end else if (f[4] != 8'h00 || f[5] == 8'h00 || f[5] > 8'h02) begin
            queue_exception(f[1], EXC_ILL_ADDR);
        end else begin
            msg[3] = {8{last_temp[7]}};
            msg[4] = last_temp;
            if (f[5] == 8'h01) begin
                msg[2] = BYTES_ONE_REG;
                queue_reply(msg, 5);
            end else begin
                msg[2] = BYTES_TWO_REG;
                msg[5] = 8'h00;
                msg[6] = {1'b0, last_hum};
                queue_reply(msg, 7);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            station   = STATION_RST;
            temp_lo   = TEMP_LO_RST;
            temp_hi   = TEMP_HI_RST;
            hum_lo    = HUM_LO_RST;
            hum_hi    = HUM_HI_RST;
            last_temp = 8'h00;
            last_hum  = 7'h00;
            expected_words.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                station = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_FRAME) begin
                    predict_frame(s_tdata[63:0]);
                end else begin
                    last_temp = s_tdata[71:64];
                    last_hum  = s_tdata[78:72];
                    t_val     = $signed(last_temp);
                    alarm     = t_val < int'(temp_lo) || t_val > int'(temp_hi)
                                || int'(last_hum) < int'(hum_lo)
                                || int'(last_hum) > int'(hum_hi);
                    expected_words.push_back('{RESULT_STATUS, 8'h00, 1'b0, alarm});
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    report("word with nothing pending", m_tdata, 0);
                end else begin
                    w = expected_words.pop_front();
                    if (m_tuser != w.kind)       report("result kind", m_tuser, w.kind);
                    if (m_tdata[7:0] != w.data)  report("tx byte", m_tdata[7:0], w.data);
                    if (m_tlast != w.last)       report("last byte", m_tlast, w.last);
                    if (m_tdata[8] != w.alarm)   report("alarm", m_tdata[8], w.alarm);
                    if (w.kind == RESULT_STATUS) begin
                        statuses++;
                    end else if (w.last) begin
                        replies++;
                    end
                end
            end
        end
        pending_count <= expected_words.size();
        fail_count    <= errors;
        reply_count   <= replies;
        status_count  <= statuses;
    end

endmodule

[tb/sv/tb_modbus_sensor_slave_responder.sv]
// ----------------------------------------------------------------------------
// tb_modbus_sensor_slave_responder - top of the responder testbench
// Drives request frames and measurements on s_, stalls m_ at random and
// rewrites the station address between phases. A directed pass walks every
// function, register and count case, then random phases run mostly
// well-formed frames mixed with foreign, corrupted and noise words.
// ----------------------------------------------------------------------------
module tb_modbus_sensor_slave_responder;

    import mbss_pkg::*;
    import mbss_tb_pkg::*;

    localparam int PER_PHASE = 47;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;
    logic        s_tuser   = OP_FRAME;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    int          fail_count;
    int          pending_count;
    int          reply_count;
    int          status_count;

    logic [7:0]  station = STATION_RST;
    logic [7:0]  stations [6];
    bit          gaps_on = 1'b1;
    int          n_frames = 0;
    int          n_meas = 0;

    always #1 aclk = ~aclk;

    modbus_sensor_slave_responder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    mbss_reply_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .reply_count   (reply_count),
        .status_count  (status_count)
    );

    initial begin
        #1_500_000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: runs of ready broken by short and occasional long stalls
    initial begin
        int run;
        int stall;
        int r;
        @(posedge aclk);
        forever begin
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                              : $urandom_range(1, 30);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
            r     = $urandom_range(0, 9);
            stall = (r < 6) ? $urandom_range(1, 2) : (r < 9) ? 0 : $urandom_range(8, 30);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    task automatic send_word(input logic op, input logic [79:0] data);
        int gap;
        int r;
        gap = 0;
        if (gaps_on) begin
            r = $urandom_range(0, 99);
            if (r >= 90) begin
                gap = $urandom_range(8, 25);
            end else if (r >= 55) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_frame(input logic [7:0] a, input logic [7:0] f, input logic [7:0] b2,
                              input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5,
                              input logic [15:0] crc_flip);
        logic [7:0][7:0] fr;
        logic [15:0]     crc;
        fr    = {16'h0000, b5, b4, b3, b2, f, a};
        crc   = modbus_crc({8'h00, fr}, 6) ^ crc_flip;
        fr[6] = crc[7:0];
        fr[7] = crc[15:8];
        send_word(OP_FRAME, {1'b0, 7'($urandom), 8'($urandom), fr});
        n_frames++;
    endtask

    task automatic send_meas(input logic [7:0] t, input logic [6:0] h);
        send_word(OP_MEAS, {1'b0, h, t, $urandom, $urandom});
        n_meas++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_station(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        station = v;
    endtask

    initial begin
        int          counted;
        int          r;
        logic [7:0]  func;
        logic [15:0] regaddr;
        logic [7:0]  lo;
        logic [7:0]  hi;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed pass at the reset station address
        send_meas(8'd0, 7'd0);
        send_frame(station, FUNC_RD_INPUT, 8'h00, REG_TEMP, 8'h00, 8'h01, 16'h0);
        send_meas(8'h80, 7'd127);
        send_frame(station, FUNC_RD_INPUT, 8'h00, REG_TEMP, 8'h00, 8'h02, 16'h0);
        send_frame(station, FUNC_RD_INPUT, 8'h00, REG_HUM, 8'h00, 8'h01, 16'h0);
        send_frame(station, FUNC_RD_HOLD, 8'h00, REG_TEMP, 8'h00, 8'h00, 16'h0);
        send_frame(station, FUNC_RD_HOLD, 8'h00, REG_HUM, 8'hff, 8'hff, 16'h0);
        send_frame(station, FUNC_WR_SINGLE, 8'h00, REG_TEMP, 8'h00, 8'hff, 16'h0);
        send_meas(8'hff, 7'd50);
        send_meas(8'h7f, 7'd50);
        send_frame(station, FUNC_WR_SINGLE, 8'h00, REG_HUM, 8'd20, 8'd30, 16'h0);
        send_meas(8'd20, 7'd25);
        send_meas(8'd20, 7'd31);
        send_frame(station, 8'h00, 8'h00, REG_TEMP, 8'h00, 8'h01, 16'h0);
        send_frame(station, 8'hff, 8'h00, REG_TEMP, 8'h00, 8'h01, 16'h0);
        send_frame(station, FUNC_RD_HOLD, 8'h01, REG_TEMP, 8'h00, 8'h01, 16'h0);
        send_frame(station, FUNC_RD_INPUT, 8'h00, 8'h00, 8'h00, 8'h01, 16'h0);
        send_frame(station, FUNC_WR_SINGLE, 8'h00, 8'h03, 8'h00, 8'h00, 16'h0);
        send_frame(station, FUNC_RD_INPUT, 8'h00, REG_TEMP, 8'h00, 8'h00, 16'h0);
        send_frame(station, FUNC_RD_INPUT, 8'h00, REG_TEMP, 8'h00, 8'h03, 16'h0);
        send_frame(station, FUNC_RD_INPUT, 8'h00, REG_TEMP, 8'h01, 8'h01, 16'h0);
        send_frame(station, FUNC_RD_INPUT, 8'h00, REG_HUM, 8'h00, 8'h02, 16'h0);
        send_frame(station, FUNC_RD_INPUT, 8'h00, REG_TEMP, 8'h00, 8'h01, 16'h0001);
        send_frame(8'h06, FUNC_RD_INPUT, 8'h00, REG_TEMP, 8'h00, 8'h01, 16'h0);
        send_frame(8'h00, FUNC_RD_INPUT, 8'h00, REG_TEMP, 8'h00, 8'h01, 16'h0);
        wait_idle();

        stations[0] = 8'd1;
        stations[1] = 8'd247;
        stations[2] = 8'd0;
        stations[3] = 8'd255;
        stations[4] = 8'($urandom_range(1, 247));
        stations[5] = STATION_RST;

        foreach (stations[p]) begin
            write_station(stations[p]);
            gaps_on = ($urandom_range(0, 3) != 0);
            counted = 0;
            while (counted < PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    send_meas(8'($urandom), 7'($urandom));
                    counted++;
                end else begin
                    r       = $urandom_range(0, 9);
                    func    = (r < 3) ? FUNC_RD_INPUT : (r < 5) ? FUNC_RD_HOLD
                            : (r < 8) ? FUNC_WR_SINGLE : 8'($urandom);
                    regaddr = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(1, 2))
                                                         : 16'($urandom);
                    if (func == FUNC_WR_SINGLE && $urandom_range(0, 3) != 0) begin
                        lo = 8'($urandom_range(0, 40));
                        hi = 8'($urandom_range(20, 130));
                    end else if ($urandom_range(0, 4) == 0) begin
                        {hi, lo} = 16'($urandom);
                    end else begin
                        lo = 8'h00;
                        hi = 8'($urandom_range(0, 3));
                    end
                    r = $urandom_range(0, 99);
                    if (r < 75) begin
                        send_frame(station, func, regaddr[15:8], regaddr[7:0], lo, hi, 16'h0);
                        counted++;
                    end else if (r < 87) begin
                        send_frame(8'($urandom), func, regaddr[15:8], regaddr[7:0], lo, hi,
                                   16'h0);
                    end else if (r < 95) begin
                        send_frame(station, func, regaddr[15:8], regaddr[7:0], lo, hi,
                                   16'h0001 << $urandom_range(0, 15));
                    end else begin
                        send_word(OP_FRAME, {1'b0, 15'($urandom), $urandom, $urandom});
                    end
                end
            end
            wait_idle();
        end

        $display("sent %0d request frames and %0d measurements across %0d station settings",
                 n_frames, n_meas, 7);
        $display("checked %0d complete replies and %0d alarm statuses",
                 reply_count, status_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
